### src/pcg32_random_generator_assert.svh
// Assertion macros for the generator's port checker.
`ifndef PCG32_RANDOM_GENERATOR_ASSERT_SVH
`define PCG32_RANDOM_GENERATOR_ASSERT_SVH

// Check a property at every clock edge, including while reset is held.
`define PCG32_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");

// Check a property, ignoring the edges at which reset is held.
`define PCG32_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");

`endif

### src/pcg32_pkg.sv
// Types and constants shared by the generator's controller and datapath.
`default_nettype none

package pcg32_pkg;

   localparam logic [63:0] PCG_RESET  = 64'h853C_49E6_748F_EA9B;
   localparam logic [63:0] PCG_MULT   = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] PCG_INC    = 64'h1405_7B7E_F767_814F;
   localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_K1     = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_K2     = 64'h94D0_49BB_1331_11EB;

   localparam logic [1:0] OP_RESEED = 2'd0;
   localparam logic [1:0] OP_RAW    = 2'd1;
   localparam logic [1:0] OP_RANGE  = 2'd2;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEED_K1,
      ST_SEED_K2,
      ST_SEED_GOLD,
      ST_DRAW_MUL,
      ST_DIVIDE,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      KC_MULT,
      KC_K1,
      KC_K2,
      KC_GOLD
   } mul_const_type;

   typedef enum logic [2:0] {
      POST_NONE,
      POST_MIX30,
      POST_MIX27,
      POST_SEED,
      POST_LCG
   } post_op_type;

   typedef struct packed {
      logic          load;
      logic          mul_en;
      logic [1:0]    mul_step;
      mul_const_type mul_const;
      post_op_type   post_op;
      logic          div_step;
      logic          finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       range_empty;
      logic       span_zero;
      logic       out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

### src/pcg32_random_generator.sv
// PCG32 XSH-RR generator with splitmix64 reseeding and a bounded-integer draw.
// One request at a time; the result sits in an output register, so the next
// request is taken while the previous result waits. A request passes through
// a decode state, then the shared 32x32 multiplier (once for a draw, three
// times for a reseed) and, for a range draw that is not the full 2^32 span,
// the remainder unit; an empty range or unused opcode goes straight from
// decode to loading the output register. The multiplier builds each 64-bit
// product from three partial products and then a step to fold the result back,
// and the remainder unit resolves one bit of raw mod span per cycle, 32 steps
// in all.
`default_nettype none

module pcg32_random_generator
   import pcg32_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // seed_value[31:0], range_low[63:32], range_high[95:64]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata    // raw_value[31:0], int_value[63:32]
);

   dp_cmd_type    cmd;
   dp_status_type status;

   pcg32_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcg32_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

### src/pcg32_ctrl.sv
// Sequencer for the generator: steps the shared multiplier and the remainder unit.
`default_nettype none

module pcg32_ctrl
   import pcg32_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type         state_ff, state_in;
   logic [1:0]             step_ff, step_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      req_tready    = 1'b0;
      cmd.load      = 1'b0;
      cmd.mul_en    = 1'b0;
      cmd.mul_step  = step_ff;
      cmd.mul_const = KC_MULT;
      cmd.post_op   = POST_NONE;
      cmd.div_step  = 1'b0;
      cmd.finish    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = 2'd0;
               cnt_in   = '0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_RESEED: state_in = ST_SEED_K1;
               OP_RAW:    state_in = ST_DRAW_MUL;
               OP_RANGE:  state_in = status.range_empty ? ST_DONE : ST_DRAW_MUL;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_SEED_K1: begin
            cmd.mul_const = KC_K1;
            cmd.mul_en    = (step_ff != 2'd3);
            step_in       = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               cmd.post_op = POST_MIX30;
               state_in    = ST_SEED_K2;
            end
         end
         ST_SEED_K2: begin
            cmd.mul_const = KC_K2;
            cmd.mul_en    = (step_ff != 2'd3);
            step_in       = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               cmd.post_op = POST_MIX27;
               state_in    = ST_SEED_GOLD;
            end
         end
         ST_SEED_GOLD: begin
            cmd.mul_const = KC_GOLD;
            cmd.mul_en    = (step_ff != 2'd3);
            step_in       = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               cmd.post_op = POST_SEED;
               state_in    = ST_DONE;
            end
         end
         ST_DRAW_MUL: begin
            cmd.mul_const = KC_MULT;
            cmd.mul_en    = (step_ff != 2'd3);
            step_in       = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               cmd.post_op = POST_LCG;
               // a full 2^32 span needs no remainder
               if (status.op == OP_RANGE && !status.span_zero) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/pcg32_datapath.sv
// Generator datapath: state, shared 32x32 multiplier, remainder unit and output register.
`default_nettype none

module pcg32_datapath
   import pcg32_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [95:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,
   input  wire dp_cmd_type  cmd,
   output dp_status_type    status
);

   logic [63:0] state_ff, state_in;
   logic [63:0] work_ff, work_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] span_ff, span_in;
   logic        empty_ff, empty_in;
   logic [31:0] raw_ff, raw_in;
   logic [31:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [31:0] req_seed;
   logic [31:0] req_low;
   logic [31:0] req_high;
   logic [31:0] xsh_mixed;
   logic [63:0] xsh_rot;
   logic [31:0] xsh_out;
   logic [63:0] mul_k;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] product;
   logic [32:0] rem_shift;
   logic [31:0] offset;
   logic [31:0] int_result;

   assign req_seed = req_tdata[31:0];
   assign req_low  = req_tdata[63:32];
   assign req_high = req_tdata[95:64];

   // XSH-RR output of the current state; rotate by duplicating the word
   assign xsh_mixed = 32'((state_ff ^ (state_ff >> 18)) >> 27);
   assign xsh_rot   = {xsh_mixed, xsh_mixed} >> state_ff[63:59];
   assign xsh_out   = xsh_rot[31:0];

   always_comb begin
      case (cmd.mul_const)
         KC_K1:   mul_k = MIX_K1;
         KC_K2:   mul_k = MIX_K2;
         KC_GOLD: mul_k = MIX_GOLDEN;
         default: mul_k = PCG_MULT;
      endcase
   end

   // step 0: lo*lo, step 1: lo*khi, step 2: hi*klo; upper cross terms fall off
   assign mul_a   = (cmd.mul_step == 2'd2) ? work_ff[63:32] : work_ff[31:0];
   assign mul_b   = (cmd.mul_step == 2'd1) ? mul_k[63:32] : mul_k[31:0];
   assign product = mul_a * mul_b;

   assign rem_shift = {rem_ff[31:0], quot_ff[31]};

   assign offset     = (span_ff == 32'd0) ? raw_ff : rem_ff[31:0];
   assign int_result = low_ff + offset;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      acc_in       = acc_ff;
      op_in        = op_ff;
      low_in       = low_ff;
      span_in      = span_ff;
      empty_in     = empty_ff;
      raw_in       = raw_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         op_in    = req_tuser;
         low_in   = req_low;
         span_in  = req_high - req_low + 32'd1;
         empty_in = ($signed(req_high) <= $signed(req_low));
         raw_in   = xsh_out;
         quot_in  = xsh_out;
         rem_in   = '0;
         work_in  = (req_tuser == OP_RESEED) ? ({32'd0, req_seed} ^ MIX_GOLDEN) : state_ff;
      end

      if (cmd.mul_en) begin
         if (cmd.mul_step == 2'd0) begin
            acc_in = product;
         end else begin
            acc_in[63:32] = acc_ff[63:32] + product[31:0];
         end
      end

      case (cmd.post_op)
         POST_MIX30: work_in  = acc_ff ^ (acc_ff >> 30);
         POST_MIX27: work_in  = acc_ff ^ (acc_ff >> 27);
         POST_SEED:  state_in = acc_ff ^ (acc_ff >> 31);
         POST_LCG:   state_in = acc_ff + PCG_INC;
         default:    ;
      endcase

      // one restoring step per cycle; only the remainder is kept
      if (cmd.div_step) begin
         quot_in = {quot_ff[30:0], 1'b0};
         if (rem_shift >= {1'b0, span_ff}) begin
            rem_in = rem_shift - {1'b0, span_ff};
         end else begin
            rem_in = rem_shift;
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         unique case (op_ff)
            OP_RAW: begin
               rsp_data_in = {32'd0, raw_ff};
            end
            OP_RANGE: begin
               if (empty_ff) begin
                  rsp_data_in = {low_ff, 32'd0};
               end else begin
                  rsp_data_in = {int_result, raw_ff};
               end
            end
            default: begin
               rsp_data_in = 64'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PCG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      acc_ff      <= acc_in;
      op_ff       <= op_in;
      low_ff      <= low_in;
      span_ff     <= span_in;
      empty_ff    <= empty_in;
      raw_ff      <= raw_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.op          = op_ff;
   assign status.range_empty = empty_ff;
   assign status.span_zero   = (span_ff == 32'd0);
   assign status.out_busy    = rsp_valid_ff && !rsp_tready;

endmodule

`default_nettype wire

### src/pcg32_checker.sv
// Port-level checks for the generator, bound to its top level.
`default_nettype none

`include "pcg32_random_generator_assert.svh"

module pcg32_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   // no result may be pending straight out of reset
   `PCG32_ASSERT(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)

   // one request at a time: the input closes after every transfer
   `PCG32_ASSERT_RST(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready)

   // a result never appears in the cycle right after its request was taken
   `PCG32_ASSERT_RST(a_no_instant_result, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))

   // a stalled result holds
   `PCG32_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))

endmodule

bind pcg32_random_generator pcg32_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/sv/pcg32_draw_checker.sv
// Checker for the PCG32 generator: predicts every draw and compares it with the result channel.
module pcg32_draw_checker
   import pcg32_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,   // seed_value[31:0], range_low[63:32], range_high[95:64]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,   // raw_value[31:0], int_value[63:32]
   output int               failures,
   output int               pending
);

   localparam logic [63:0] LCG_START      = 64'h853C_49E6_748F_EA9B;
   localparam logic [63:0] LCG_MULTIPLIER = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] LCG_INCREMENT  = 64'h1405_7B7E_F767_814F;
   localparam logic [63:0] SEED_GOLDEN    = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] SEED_K1        = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] SEED_K2        = 64'h94D0_49BB_1331_11EB;

   typedef struct packed {
      logic [31:0] raw_value;
      logic [31:0] int_value;
   } draw_type;

   logic [63:0] lcg_state;
   draw_type    expected_draws[$];

   // XSH-RR output of the current state, then advance the LCG
   function automatic logic [31:0] draw_raw_value();
      logic [4:0]  rot;
      logic [31:0] folded;
      logic [63:0] twice;
      rot       = lcg_state[63:59];
      folded    = 32'((lcg_state ^ (lcg_state >> 18)) >> 27);
      twice     = {folded, folded} >> rot;
      lcg_state = lcg_state * LCG_MULTIPLIER + LCG_INCREMENT;
      return twice[31:0];
   endfunction

   function automatic logic [63:0] mixed_seed(logic [31:0] seed);
      logic [63:0] z;
      z = ({32'd0, seed} ^ SEED_GOLDEN) * SEED_K1;
      z = (z ^ (z >> 30)) * SEED_K2;
      z = (z ^ (z >> 27)) * SEED_GOLDEN;
      return z ^ (z >> 31);
   endfunction

   function automatic draw_type predict_draw(logic [1:0] op, logic [95:0] fields);
      draw_type    d;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] span;
      logic [31:0] r;
      d  = '0;
      lo = fields[63:32];
      hi = fields[95:64];
      case (op)
         OP_RESEED: lcg_state = mixed_seed(fields[31:0]);
         OP_RAW:    d.raw_value = draw_raw_value();
         OP_RANGE: begin
            if ($signed(hi) <= $signed(lo)) begin
               // empty range: give the lower bound, leave the state alone
               d.int_value = lo;
            end else begin
               r    = draw_raw_value();
               span = hi - lo + 32'd1;
               d.raw_value = r;
               // a span of zero means the full 2^32 range
               d.int_value = lo + ((span == 32'd0) ? r : r % span);
            end
         end
         default: ;
      endcase
      return d;
   endfunction

   // queue a prediction behind the ones still outstanding
   function automatic void append_draw(draw_type d);
      expected_draws = {expected_draws, d};
   endfunction

   always @(posedge clock) begin : watch
      draw_type want;
      if (reset) begin
         lcg_state = LCG_START;
         expected_draws.delete();
      end else begin
         if (req_tvalid && req_tready)
            append_draw(predict_draw(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_draws.size() == 0) begin
               $error("result transfer with nothing outstanding: raw_value %h int_value %h",
                      rsp_tdata[31:0], rsp_tdata[63:32]);
               failures++;
            end else begin
               want = expected_draws.pop_front();
               if (rsp_tdata[31:0] !== want.raw_value) begin
                  $error("raw_value: expected %h, actual %h", want.raw_value, rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[63:32] !== want.int_value) begin
                  $error("int_value: expected %h, actual %h", want.int_value, rsp_tdata[63:32]);
                  failures++;
               end
            end
         end
      end
      pending = expected_draws.size();
   end

endmodule

### tb/sv/pcg32_random_generator_test.sv
// Top of the PCG32 generator testbench: clock, reset, request and result traffic, verdict.
module pcg32_random_generator_test;
   import pcg32_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 550;
   localparam int         CALM_TAIL    = 80;
   localparam int         HOLD_START   = 3000;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         DRAIN_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;   // seed_value[31:0], range_low[63:32], range_high[95:64]
   logic [1:0]  req_tuser;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // raw_value[31:0], int_value[63:32]
   int          failures;
   int          pending;
   bit          calm;

   pcg32_random_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pcg32_draw_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: random stall bursts, one long hold-off so the request side backs up
   initial begin : receiver
      int stall;
      int cycle;
      stall      = 0;
      cycle      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle == HOLD_START) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall      = $urandom_range(1, 6) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Present one request and hold it until the transfer completes
   task automatic offer(input logic [1:0] op, input logic [31:0] seed,
                        input logic [31:0] lo, input logic [31:0] hi);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {hi, lo, seed};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_random_item();
      logic [31:0] lo;
      logic [31:0] hi;
      int          pick;
      pick = $urandom_range(0, 99);
      lo   = $urandom();
      hi   = $urandom();
      if (pick < 12) begin
         offer(OP_RESEED, $urandom(), lo, hi);
      end else if (pick < 42) begin
         offer(OP_RAW, $urandom(), lo, hi);
      end else if (pick < 96) begin
         case ($urandom_range(0, 9))
            0, 1, 2: hi = lo + $urandom_range(1, 16);
            3, 4:    hi = lo + $urandom_range(1, 1000);
            5:       ;
            6:       hi = lo - $urandom_range(0, 3);
            7: begin
               // around the full signed span
               lo = 32'h8000_0000 + $urandom_range(0, 3);
               hi = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            8: begin
               lo = 32'd0 - $urandom_range(0, 100);
               hi = $urandom_range(0, 100);
            end
            default: hi = lo + ($urandom() >> $urandom_range(0, 31));
         endcase
         offer(OP_RANGE, $urandom(), lo, hi);
      end else begin
         offer(OP_UNUSED, $urandom(), lo, hi);
      end
   endtask

   initial begin
      reset      = 1'b1;
      calm       = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_RESEED;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // draws from the reset state
      offer(OP_RAW,    32'h0,         32'h0,         32'h0);
      offer(OP_RAW,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // full span, one short of it, and empty ranges
      offer(OP_RANGE,  32'h0,         32'h8000_0000, 32'h7FFF_FFFF);
      offer(OP_RANGE,  32'h0,         32'h8000_0000, 32'h7FFF_FFFE);
      offer(OP_RANGE,  32'h0,         32'h7FFF_FFFF, 32'h8000_0000);
      offer(OP_RANGE,  32'h0,         32'd5,         32'd5);
      offer(OP_RANGE,  32'h0,         32'd10,        32'hFFFF_FFFD);
      offer(OP_RANGE,  32'h0,         32'd0,         32'd1);
      offer(OP_RANGE,  32'h0,         32'hFFFF_FFFF, 32'd0);
      offer(OP_RANGE,  32'h0,         32'd0,         32'h7FFF_FFFF);
      offer(OP_RANGE,  32'h0,         32'h8000_0000, 32'h8000_0001);
      offer(OP_RANGE,  32'h0,         32'h7FFF_FFFE, 32'h7FFF_FFFF);
      // unused code must leave the state alone
      offer(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(OP_UNUSED, 32'h0,         32'd0,         32'd7);
      offer(OP_RAW,    32'h0,         32'h0,         32'h0);
      // seed extremes, and a repeated seed
      offer(OP_RESEED, 32'h0,         32'h0,         32'h0);
      offer(OP_RAW,    32'h0,         32'h0,         32'h0);
      offer(OP_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(OP_RAW,    32'h0,         32'h0,         32'h0);
      offer(OP_RANGE,  32'h0,         32'd0,         32'd9);
      offer(OP_RESEED, 32'h0,         32'h0,         32'h0);
      offer(OP_RAW,    32'h0,         32'h0,         32'h0);
      offer(OP_RESEED, 32'h8000_0001, 32'h0,         32'h0);
      offer(OP_RANGE,  32'h0,         32'h8000_0000, 32'h7FFF_FFFF);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_TAIL)
            calm = 1'b1;
         send_random_item();
      end
      req_tvalid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/pcg32_pkg.sv
src/pcg32_ctrl.sv
src/pcg32_datapath.sv
src/pcg32_random_generator.sv
src/pcg32_checker.sv
tb/sv/pcg32_draw_checker.sv
tb/sv/pcg32_random_generator_test.sv
